// ===== hw/rtl/quaternion_to_euler_angles_assert.svh =====
// Assertion macros for the quaternion to Euler angle converter.
// Used by the top level only; needs no package.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion_to_euler_angles check failed");

// Consequent must hold in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion_to_euler_angles check failed");

`endif

// ===== hw/rtl/qte_pkg.sv =====
// Shared widths, stage types and the arctangent table of the quaternion converter.
// No dependencies.
package qte_pkg;

   localparam int Q_W         = 16;
   localparam int ROLL_W      = 16;
   localparam int PITCH_W     = 15;
   localparam int HEAD_W      = 16;
   localparam int DECL_W      = 16;
   localparam int PROD_W      = 32;
   localparam int TERM_W      = 35;
   localparam int VEC_W       = 38;
   localparam int ACC_W       = 33;
   localparam int ANG_W       = 17;
   localparam int SIN_W       = 30;
   localparam int RAD_W       = 57;
   localparam int COS_W       = 29;
   localparam int STAGE_LIMIT = 24;
   localparam int SQRT_STAGES = 29;
   localparam int PITCH_DELAY = 3 + SQRT_STAGES;

   localparam logic signed [TERM_W-1:0] ONE_Q28       = TERM_W'(64'sd268435456);
   localparam logic signed [ACC_W-1:0]  HALF_TURN_ACC = 33'sd1179648000;
   localparam logic        [RAD_W-1:0]  SQRT_TOP      = RAD_W'(1) << 56;

   localparam logic [ACC_W-1:0] ATAN_TAB [STAGE_LIMIT] = '{
      33'd294912000, 33'd174096719, 33'd91987925, 33'd46694507,
      33'd23437865,  33'd11730358,  33'd5866610,  33'd2933484,
      33'd1466764,   33'd733385,    33'd366693,   33'd183346,
      33'd91673,     33'd45837,     33'd22918,    33'd11459,
      33'd5730,      33'd2865,      33'd1432,     33'd716,
      33'd358,       33'd179,       33'd90,       33'd45
   };

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ACC_W-1:0] acc;
      logic                    zero;
   } cordic_vec_type;

   typedef struct packed {
      logic        [RAD_W-1:0] rem;
      logic        [RAD_W-1:0] root;
      logic signed [SIN_W-1:0] sin;
   } sqrt_vec_type;

endpackage

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Throughput: one beat per cycle while the row is not stalled.
// The sqrt row (29 cells) and the CORDIC rows set the depth.
// The whole row advances unless a held rsp beat would be overwritten.
// Reset clears all stage valids, the output valid and the declination register.
// Depends on qte_pkg, qte_cordic_lane, qte_sqrt_cell and the assertion header.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qte_pkg::Q_W-1:0]     req_quat_w,
   input  logic signed [qte_pkg::Q_W-1:0]     req_quat_x,
   input  logic signed [qte_pkg::Q_W-1:0]     req_quat_y,
   input  logic signed [qte_pkg::Q_W-1:0]     req_quat_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qte_pkg::ROLL_W-1:0]  rsp_roll_centideg,
   output logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_centideg,
   output logic        [qte_pkg::HEAD_W-1:0]  rsp_heading_centideg,
   input  logic                               csr_wr_en,
   input  logic signed [qte_pkg::DECL_W-1:0]  csr_wr_data
);
   import qte_pkg::*;
   `include "quaternion_to_euler_angles_assert.svh"

   localparam int DEPTH = 37 + CORDIC_STAGES;

   logic en;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic last_valid;
   logic signed [DECL_W-1:0] decl_ff;

   logic signed [Q_W-1:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, wx_ff, wy_ff, wz_ff, xy_ff, xz_ff,
      yz_ff;
   logic signed [TERM_W-1:0] r11_ff, r21_ff, r31_ff, r32_ff, r33_ff;
   logic signed [SIN_W-1:0] sin_ff, sin2_ff, sin3_ff;
   logic [RAD_W-1:0] s2_ff;
   logic [RAD_W-1:0] rad_ff;
   sqrt_vec_type sq_q [SQRT_STAGES+1];

   logic signed [ANG_W-1:0] roll_a, yaw_a, pitch_a;
   logic signed [ANG_W-1:0] roll_dl_ff [PITCH_DELAY];
   logic signed [ANG_W-1:0] yaw_dl_ff [PITCH_DELAY];
   logic signed [TERM_W-1:0] cos_t, sin_t;
   logic signed [2*SIN_W-1:0] sq_full;

   logic signed [ANG_W-1:0] roll_d, yaw_d, pitch_neg;
   logic signed [ROLL_W-1:0] roll_in;
   logic signed [PITCH_W-1:0] pitch_in;
   logic [HEAD_W-1:0] head_in;
   logic signed [18:0] head_sum;
   logic signed [18:0] head_wrap;
   logic rsp_valid_ff;
   logic signed [ROLL_W-1:0] roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic [HEAD_W-1:0] head_ff;

   assign last_valid = valid_ff[DEPTH-1];
   assign en = !(rsp_valid_ff && rsp_stall && last_valid);
   assign req_stall = !en;
   assign valid_in = {valid_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         decl_ff <= '0;
      end else begin
         if (en) begin
            valid_ff <= valid_in;
         end
         if (csr_wr_en) begin
            decl_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= req_quat_w;
         x_ff <= req_quat_x;
         y_ff <= req_quat_y;
         z_ff <= req_quat_z;
         ww_ff <= w_ff * w_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         zz_ff <= z_ff * z_ff;
         wx_ff <= w_ff * x_ff;
         wy_ff <= w_ff * y_ff;
         wz_ff <= w_ff * z_ff;
         xy_ff <= x_ff * y_ff;
         xz_ff <= x_ff * z_ff;
         yz_ff <= y_ff * z_ff;
         r11_ff <= TERM_W'(ww_ff) + TERM_W'(xx_ff) - TERM_W'(yy_ff) - TERM_W'(zz_ff);
         r33_ff <= TERM_W'(ww_ff) - TERM_W'(xx_ff) - TERM_W'(yy_ff) + TERM_W'(zz_ff);
         r21_ff <= (TERM_W'(wz_ff) + TERM_W'(xy_ff)) <<< 1;
         r31_ff <= (TERM_W'(xz_ff) - TERM_W'(wy_ff)) <<< 1;
         r32_ff <= (TERM_W'(wx_ff) + TERM_W'(yz_ff)) <<< 1;
         if (r31_ff > ONE_Q28) begin
            sin_ff <= SIN_W'(ONE_Q28);
         end else if (r31_ff < -ONE_Q28) begin
            sin_ff <= SIN_W'(-ONE_Q28);
         end else begin
            sin_ff <= SIN_W'(r31_ff);
         end
         s2_ff <= sq_full[RAD_W-1:0];
         sin2_ff <= sin_ff;
         rad_ff <= SQRT_TOP - s2_ff;
         sin3_ff <= sin2_ff;
      end
   end

   assign sq_full = (2*SIN_W)'(sin_ff) * (2*SIN_W)'(sin_ff);

   assign sq_q[0] = '{rem: rad_ff, root: '0, sin: sin3_ff};

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      qte_sqrt_cell #(.STAGE(k)) u_sqrt (
         .clock (clock),
         .en    (en),
         .vec_i (sq_q[k]),
         .vec_o (sq_q[k+1])
      );
   end

   assign cos_t = TERM_W'({1'b0, sq_q[SQRT_STAGES].root[COS_W-1:0]});
   assign sin_t = TERM_W'(sq_q[SQRT_STAGES].sin);

   qte_cordic_lane #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock (clock), .en (en), .x_i (r33_ff), .y_i (r32_ff), .angle_o (roll_a)
   );

   qte_cordic_lane #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock (clock), .en (en), .x_i (r11_ff), .y_i (r21_ff), .angle_o (yaw_a)
   );

   qte_cordic_lane #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock (clock), .en (en), .x_i (cos_t), .y_i (sin_t), .angle_o (pitch_a)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         roll_dl_ff[0] <= roll_a;
         yaw_dl_ff[0] <= yaw_a;
         for (int j = 1; j < PITCH_DELAY; j++) begin
            roll_dl_ff[j] <= roll_dl_ff[j-1];
            yaw_dl_ff[j] <= yaw_dl_ff[j-1];
         end
      end
   end

   assign roll_d = roll_dl_ff[PITCH_DELAY-1];
   assign yaw_d = yaw_dl_ff[PITCH_DELAY-1];

   always_comb begin
      if (roll_d > 18000) begin
         roll_in = ROLL_W'(18000);
      end else if (roll_d < -18000) begin
         roll_in = -ROLL_W'(18000);
      end else begin
         roll_in = ROLL_W'(roll_d);
      end
      pitch_neg = -pitch_a;
      if (pitch_neg > 9000) begin
         pitch_in = PITCH_W'(9000);
      end else if (pitch_neg < -9000) begin
         pitch_in = -PITCH_W'(9000);
      end else begin
         pitch_in = PITCH_W'(pitch_neg);
      end
      head_sum = 19'(yaw_d) + 19'(decl_ff);
      if (head_sum < -36000) begin
         head_wrap = head_sum + 19'sd72000;
      end else if (head_sum < 0) begin
         head_wrap = head_sum + 19'sd36000;
      end else if (head_sum >= 36000) begin
         head_wrap = head_sum - 19'sd36000;
      end else begin
         head_wrap = head_sum;
      end
      head_in = head_wrap[HEAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         roll_ff <= roll_in;
         pitch_ff <= pitch_in;
         head_ff <= head_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_centideg = roll_ff;
   assign rsp_pitch_centideg = pitch_ff;
   assign rsp_heading_centideg = head_ff;

   `QTE_ASSERT_NOW(a_head_range, clock, reset, rsp_valid_ff, head_ff < 16'd36000)
   `QTE_ASSERT_NOW(a_pitch_range, clock, reset, rsp_valid_ff,
      (pitch_ff <= 9000) && (pitch_ff >= -9000))
   `QTE_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
      rsp_valid_ff && rsp_stall && last_valid)
   `QTE_ASSERT_NEXT(a_last_held, clock, reset, req_stall, last_valid && rsp_valid_ff)

endmodule

// ===== hw/rtl/qte_cordic_cell.sv =====
// One vectoring CORDIC step with a fixed shift and table angle.
// Depends on qte_pkg.
module qte_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  qte_pkg::cordic_vec_type vec_i,
   output qte_pkg::cordic_vec_type vec_o
);
   import qte_pkg::*;

   cordic_vec_type vec_ff;
   cordic_vec_type vec_in;
   logic signed [VEC_W-1:0] dx;
   logic signed [VEC_W-1:0] dy;

   always_comb begin
      dx = vec_i.y >>> STAGE;
      dy = vec_i.x >>> STAGE;
      vec_in.zero = vec_i.zero;
      if (vec_i.y >= 0) begin
         vec_in.x   = vec_i.x + dx;
         vec_in.y   = vec_i.y - dy;
         vec_in.acc = vec_i.acc + $signed(ATAN_TAB[STAGE]);
      end else begin
         vec_in.x   = vec_i.x - dx;
         vec_in.y   = vec_i.y + dy;
         vec_in.acc = vec_i.acc - $signed(ATAN_TAB[STAGE]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

// ===== hw/rtl/qte_sqrt_cell.sv =====
// One restoring square root step, resolving one root bit per cell.
// Depends on qte_pkg.
module qte_sqrt_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  qte_pkg::sqrt_vec_type vec_i,
   output qte_pkg::sqrt_vec_type vec_o
);
   import qte_pkg::*;

   localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (56 - 2 * STAGE);

   sqrt_vec_type vec_ff;
   sqrt_vec_type vec_in;
   logic [RAD_W:0] trial;
   logic [RAD_W:0] half_root;

   always_comb begin
      trial     = {1'b0, vec_i.root} + BIT;
      half_root = {2'b00, vec_i.root[RAD_W-1:1]};
      vec_in.sin = vec_i.sin;
      if ({1'b0, vec_i.rem} >= trial) begin
         vec_in.rem  = RAD_W'({1'b0, vec_i.rem} - trial);
         vec_in.root = RAD_W'(half_root + BIT);
      end else begin
         vec_in.rem  = vec_i.rem;
         vec_in.root = RAD_W'(half_root);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_o = vec_ff;

endmodule

// ===== hw/rtl/qte_cordic_lane.sv =====
// Arctangent lane: half-plane fold, a row of CORDIC cells and final rounding.
// Depends on qte_pkg and qte_cordic_cell.
module qte_cordic_lane #(
   parameter int STAGES = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [qte_pkg::TERM_W-1:0] x_i,
   input  logic signed [qte_pkg::TERM_W-1:0] y_i,
   output logic signed [qte_pkg::ANG_W-1:0]  angle_o
);
   import qte_pkg::*;

   cordic_vec_type stage_q [STAGES+1];
   cordic_vec_type prep_in;
   cordic_vec_type prep_ff;
   logic signed [ACC_W-1:0] rounded;
   logic signed [ANG_W-1:0] angle_in;
   logic signed [ANG_W-1:0] angle_ff;
   logic signed [VEC_W-1:0] xe;
   logic signed [VEC_W-1:0] ye;

   always_comb begin
      xe = VEC_W'(x_i);
      ye = VEC_W'(y_i);
      prep_in.zero = (x_i == 0) && (y_i == 0);
      if (x_i < 0) begin
         prep_in.x   = -xe;
         prep_in.y   = -ye;
         prep_in.acc = (y_i >= 0) ? HALF_TURN_ACC : -HALF_TURN_ACC;
      end else begin
         prep_in.x   = xe;
         prep_in.y   = ye;
         prep_in.acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign stage_q[0] = prep_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      qte_cordic_cell #(.STAGE(i)) u_cell (
         .clock (clock),
         .en    (en),
         .vec_i (stage_q[i]),
         .vec_o (stage_q[i+1])
      );
   end

   always_comb begin
      rounded  = stage_q[STAGES].acc + ACC_W'(32768);
      angle_in = stage_q[STAGES].zero ? '0 : rounded[ACC_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle_o = angle_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for quaternion_to_euler_angles: random and directed quaternions,
// checked against a fixed-point CORDIC predictor. Depends on qte_pkg and the block.
`timescale 1ns / 100ps

module tb_top;
   import qte_pkg::*;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 37;

   typedef struct {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic        [HEAD_W-1:0]  heading;
   } angles_type;

   class scoreboard_type;
      angles_type pending_angles[$];
      logic signed [15:0] declination = 16'sd0;
      int mismatches;

      function longint shift_down(longint v, int s);
         return v >>> s;
      endfunction

      function longint cordic_angle(longint yv, longint xv);
         longint acc, dx, dy;
         acc = 0;
         if (xv == 0 && yv == 0) return 0;
         if (xv < 0) begin
            acc = (yv >= 0) ? 64'sd1179648000 : -64'sd1179648000;
            xv = -xv;
            yv = -yv;
         end
         for (int i = 0; i < STAGES && i < STAGE_LIMIT; i++) begin
            dx = shift_down(yv, i);
            dy = shift_down(xv, i);
            if (yv >= 0) begin
               xv += dx; yv -= dy; acc += longint'(ATAN_TAB[i]);
            end else begin
               xv -= dx; yv += dy; acc -= longint'(ATAN_TAB[i]);
            end
         end
         return shift_down(acc + 32768, 16);
      endfunction

      function longint root_floor(longint v);
         longint lo, hi, mid;
         lo = 0; hi = 64'sd268435457;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v) lo = mid; else hi = mid;
         end
         return lo;
      endfunction

      function longint limit(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                    logic signed [15:0] qy, logic signed [15:0] qz);
         longint w, x, y, z, r11, r21, r31, r32, r33, rl, pt, hd, c;
         angles_type a;
         w = qw; x = qx; y = qy; z = qz;
         r11 = w*w + x*x - y*y - z*z;
         r21 = 2*(w*z + x*y);
         r31 = 2*(x*z - w*y);
         r32 = 2*(w*x + y*z);
         r33 = w*w - x*x - y*y + z*z;
         rl = limit(cordic_angle(r32, r33), -18000, 18000);
         r31 = limit(r31, -64'sd268435456, 64'sd268435456);
         c = root_floor((64'sd1 << 56) - r31*r31);
         pt = limit(-cordic_angle(r31, c), -9000, 9000);
         hd = cordic_angle(r21, r11) + longint'(declination);
         while (hd < 0) hd += 36000;
         while (hd >= 36000) hd -= 36000;
         a.roll = rl[ROLL_W-1:0];
         a.pitch = pt[PITCH_W-1:0];
         a.heading = hd[HEAD_W-1:0];
         pending_angles.push_back(a);
      endfunction

      function void check_angles(angles_type got);
         angles_type e;
         if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %0d %0d %0d",
               got.roll, got.pitch, got.heading);
            return;
         end
         e = pending_angles.pop_front();
         if (e.roll !== got.roll || e.pitch !== got.pitch || e.heading !== got.heading) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp %0d %0d %0d got %0d %0d %0d", e.roll, e.pitch,
                  e.heading, got.roll, got.pitch, got.heading);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0, csr_wr_en = 0;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [15:0] csr_wr_data = 0;
   logic signed [ROLL_W-1:0] rsp_roll_centideg;
   logic signed [PITCH_W-1:0] rsp_pitch_centideg;
   logic [HEAD_W-1:0] rsp_heading_centideg;
   scoreboard_type sb = new();
   int stall_mode = 0;

   always #5 clock = ~clock;

   quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) uut (.*);

   always @(posedge clock) begin
      angles_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.roll = rsp_roll_centideg;
         got.pitch = rsp_pitch_centideg;
         got.heading = rsp_heading_centideg;
         sb.check_angles(got);
      end
      if (!reset && req_valid && !req_stall)
         sb.note_quaternion(req_quat_w, req_quat_x, req_quat_y, req_quat_z);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   always @(posedge clock) if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);

   task automatic send_beat(logic signed [15:0] w, x, y, z);
      req_valid <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_declination(logic signed [15:0] d);
      csr_wr_en <= 1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.declination = d;
   endtask

   function automatic logic signed [15:0] comp(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 32768) - 16384);
         1: return 16'($urandom);
         default: return 16'($urandom_range(0, 2048) - 1024);
      endcase
   endfunction

   task automatic send_random(int count);
      int burst;
      real n, w, x, y, z;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            if ($urandom_range(0, 9) < 7) begin
               w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
               y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
               n = $sqrt(w*w + x*x + y*y + z*z);
               if (n < 1.0) n = 1.0;
               send_beat(16'($rtoi(w*16384.0/n)), 16'($rtoi(x*16384.0/n)),
                         16'($rtoi(y*16384.0/n)), 16'($rtoi(z*16384.0/n)));
            end else begin
               send_beat(comp($urandom_range(0, 2)), comp($urandom_range(0, 2)),
                         comp($urandom_range(0, 2)), comp($urandom_range(0, 2)));
            end
            burst--; count--;
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
      end
   endtask

   initial begin
      logic signed [15:0] decls[5] = '{16'sd0, 16'sd18000, -16'sd18000, 16'sh7fff, 16'sh8000};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_beat(16384, 0, 0, 0);
      send_beat(0, 0, 0, 0);
      send_beat(-16384, 0, 0, 0);
      send_beat(0, 16384, 0, 0);
      send_beat(0, 0, 16384, 0);
      send_beat(0, 0, 0, 16384);
      send_beat(0, 0, 0, -16384);
      send_beat(11585, 0, 11585, 0);
      send_beat(11585, 0, -11585, 0);
      send_beat(16384, 16384, 16384, 16384);
      send_beat(-16384, 16384, -16384, 16384);
      send_beat(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_beat(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_beat(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001);
      send_beat(0, 11585, 0, -11585);
      send_beat(8192, -8192, 8192, -8192);
      drain();
      foreach (decls[i]) begin
         write_declination(decls[i]);
         send_beat(16384, 0, 0, 0);
         send_beat(0, 0, 0, 16384);
         send_random(140);
         drain();
      end
      write_declination(16'($urandom_range(0, 36000) - 18000));
      send_random(50);
      drain();
      if (sb.mismatches == 0 && sb.pending_angles.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end
endmodule
